### rtl/farc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// farc_pkg
// Shared constants for the fully associative cache with random replacement.
// ----------------------------------------------------------------------------
package farc_pkg;

    localparam int NUM_BLOCKS_DEF  = 16;
    localparam int BLOCK_BYTES_DEF = 64;

    localparam int ADDR_W     = 32;
    localparam int DATA_W     = 64;
    localparam int PORT_W     = 2;
    localparam int SIZE_W     = 4;
    localparam int FUNC_W     = 2;
    localparam int KIND_W     = 3;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 16;
    localparam int LFSR_W     = 16;
    localparam int CAPLOG_W   = 3;
    localparam int S_TDATA_W  = 168;
    localparam int M_TDATA_W  = 168;
    localparam int MAX_ACCESS = 8;

    localparam logic [LFSR_W-1:0]   LFSR_TAPS     = 16'hB400;
    localparam logic [LFSR_W-1:0]   LFSR_RESET    = 16'd44257;
    localparam logic [CAPLOG_W-1:0] CAPLOG_RESET  = 3'd4;

    localparam logic [FUNC_W-1:0] FN_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FILL  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_BAD   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_RESP  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RDREQ = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WB    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RETRY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_SEED     = 1'b1;

endpackage
`default_nettype wire

### rtl/farc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// farc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module farc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/fully_assoc_cache_random_replace.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fully_assoc_cache_random_replace
// Blocking, fully associative write-back cache with LFSR victim selection.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one word per CPU read, CPU write or memory fill
// word; tuser says which. The master channel returns responses, block read
// requests, writeback words, retries and errors; tuser gives the kind and
// tlast marks the final result of an input word.
// Tags and valid bits sit in flip-flops and are compared in parallel; block
// data lives in one RAM with a registered read.
// Sequence: a read hit decodes, reads two RAM words, captures them and
// responds; a write hit also writes one RAM word back, or two when the
// access crosses a word boundary. A miss, a retry or an error is answered
// from the decode state; fill words other than the last only buffer the
// word. The last fill word with eviction runs the victim modulo over the
// LFSR bits, scans up to NUM_BLOCKS slots for the victim, reads and emits
// each writeback word, installs one word per cycle, then the pending access.
// A new word is taken only when the sequencer is idle; a result waiting in
// the output register does not block acceptance, but a stalled receiver
// holds the sequencer at its next result.
// Reset (aresetn low, synchronous) clears the valid bits, counters, busy flag
// and output valid, and loads the default LFSR seed and capacity log2.
// ----------------------------------------------------------------------------
module fully_assoc_cache_random_replace #(
    parameter int NUM_BLOCKS  = farc_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = farc_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // tdata: address[31:0], access_size[35:32], write_data[99:36],
    //        fill_word[163:100], requester_port[165:164], zero[167:166]
    // tuser: func[1:0]
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [farc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [farc_pkg::FUNC_W-1:0]      s_tuser,
    // tdata: resp_port[1:0], out_address[33:2], out_data[97:34], hit[98],
    //        hit_total[130:99], miss_total[162:131], zero[167:163]
    // tuser: kind[2:0]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [farc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [farc_pkg::KIND_W-1:0]      m_tuser,
    output logic                                  m_tlast,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [farc_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int WORDS  = BLOCK_BYTES / 8;
    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int TAG_W  = farc_pkg::ADDR_W - OFF_W;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SLOT_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int VCW    = $clog2(NUM_BLOCKS + 1);
    localparam int RW     = VCW + 1;
    localparam int RAM_D  = NUM_BLOCKS * WORDS;
    localparam int RAM_AW = (RAM_D > 1) ? $clog2(RAM_D) : 1;
    localparam int CAPW   = 10;
    localparam int EXW    = OFF_W + 2;
    localparam int BITC_W = $clog2(farc_pkg::LFSR_W);
    localparam int DW     = farc_pkg::DATA_W;

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_DECODE  = 14'b00000000000010,
        ST_MOD     = 14'b00000000000100,
        ST_SCAN    = 14'b00000000001000,
        ST_WB_RD   = 14'b00000000010000,
        ST_WB_EMIT = 14'b00000000100000,
        ST_INSTALL = 14'b00000001000000,
        ST_ACC_RD0 = 14'b00000010000000,
        ST_ACC_RD1 = 14'b00000100000000,
        ST_ACC_CAP = 14'b00001000000000,
        ST_ACC_WR0 = 14'b00010000000000,
        ST_ACC_WR1 = 14'b00100000000000,
        ST_RESP    = 14'b01000000000000,
        ST_SPARE   = 14'b10000000000000
    } state_t;

    function automatic logic [RAM_AW-1:0] ram_index(input logic [SLOT_W-1:0] slot,
                                                    input logic [WIDX_W-1:0] word);
        ram_index = RAM_AW'(RAM_AW'(slot) * RAM_AW'(WORDS)) + RAM_AW'(word);
    endfunction

    // Sequencer and input registers.
    state_t state_reg, state_next;
    logic [farc_pkg::FUNC_W-1:0] in_func_reg;
    logic [farc_pkg::ADDR_W-1:0] in_addr_reg;
    logic [farc_pkg::SIZE_W-1:0] in_size_reg;
    logic [DW-1:0]               in_wdata_reg;
    logic [DW-1:0]               in_fword_reg;
    logic [farc_pkg::PORT_W-1:0] in_port_reg;

    // Cache state.
    logic [farc_pkg::CAPLOG_W-1:0] cap_log2_reg;
    logic [farc_pkg::LFSR_W-1:0]   lfsr_reg, lfsr_next;
    logic                          busy_reg, busy_next;
    logic [VCW-1:0]                vc_reg, vc_next;
    logic [farc_pkg::CNT_W-1:0]    hits_reg, hits_next;
    logic [farc_pkg::CNT_W-1:0]    misses_reg, misses_next;
    logic [NUM_BLOCKS-1:0]         valid_reg, valid_next;
    logic [TAG_W-1:0]              tag_reg [NUM_BLOCKS];
    logic [DW-1:0]                 fill_buf_reg [WORDS];
    logic [WIDX_W-1:0]             fill_cnt_reg, fill_cnt_next;

    // Pending or current access.
    logic                          pend_write_reg, pend_write_next;
    logic [farc_pkg::ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [farc_pkg::SIZE_W-1:0]   pend_size_reg, pend_size_next;
    logic [DW-1:0]                 pend_data_reg, pend_data_next;
    logic [farc_pkg::PORT_W-1:0]   pend_port_reg, pend_port_next;
    logic [SLOT_W-1:0]             slot_reg, slot_next;
    logic                          acc_hit_reg, acc_hit_next;
    logic [WIDX_W-1:0]             wcnt_reg, wcnt_next;
    logic [DW-1:0]                 w0_reg, w0_next;
    logic [DW-1:0]                 w1_reg, w1_next;

    // Victim selection.
    logic [RW-1:0]                 rem_reg, rem_next;
    logic [farc_pkg::LFSR_W-1:0]   modq_reg, modq_next;
    logic [BITC_W-1:0]             bitc_reg, bitc_next;
    logic [SLOT_W-1:0]             scan_reg, scan_next;
    logic [VCW-1:0]                seen_reg, seen_next;

    // Output register.
    logic                          m_valid_reg;
    logic [farc_pkg::KIND_W-1:0]   m_kind_reg;
    logic [farc_pkg::PORT_W-1:0]   m_port_reg;
    logic [farc_pkg::ADDR_W-1:0]   m_addr_reg;
    logic [DW-1:0]                 m_data_reg;
    logic                          m_hit_reg;
    logic                          m_last_reg;
    logic [farc_pkg::CNT_W-1:0]    m_hits_reg;
    logic [farc_pkg::CNT_W-1:0]    m_misses_reg;

    // Result produced this cycle.
    logic                          emit;
    logic [farc_pkg::KIND_W-1:0]   e_kind;
    logic [farc_pkg::PORT_W-1:0]   e_port;
    logic [farc_pkg::ADDR_W-1:0]   e_addr;
    logic [DW-1:0]                 e_data;
    logic                          e_hit;
    logic                          e_last;

    // Array write strobes.
    logic                          tag_we;
    logic [TAG_W-1:0]              tag_wdata;
    logic                          fill_we;

    // RAM port.
    logic                          ram_we;
    logic [RAM_AW-1:0]             ram_waddr;
    logic [DW-1:0]                 ram_wdata;
    logic [RAM_AW-1:0]             ram_raddr;
    logic [DW-1:0]                 ram_rdata;

    logic out_free;
    logic accept;

    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Lookup of the registered request against all valid tags.
    logic [OFF_W-1:0]  in_off;
    logic [TAG_W-1:0]  in_tag;
    logic              bad_access;
    logic              hit_found;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] free_slot;

    assign in_off = in_addr_reg[OFF_W-1:0];
    assign in_tag = in_addr_reg[farc_pkg::ADDR_W-1:OFF_W];
    assign bad_access = (in_size_reg == '0)
                     || (in_size_reg > farc_pkg::SIZE_W'(farc_pkg::MAX_ACCESS))
                     || ((EXW'(in_off) + EXW'(in_size_reg)) > EXW'(BLOCK_BYTES));

    always_comb begin
        hit_found = 1'b0;
        hit_slot  = '0;
        for (int s = 0; s < NUM_BLOCKS; s++) begin
            if (valid_reg[s] && (tag_reg[s] == in_tag)) begin
                hit_found = 1'b1;
                hit_slot  = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        free_slot = '0;
        for (int s = NUM_BLOCKS - 1; s >= 0; s--) begin
            if (!valid_reg[s]) begin
                free_slot = SLOT_W'(s);
            end
        end
    end

    // Capacity check: blocks in use against 2^capacity_log2, saturated.
    logic [CAPW-1:0] cap_raw;
    logic [CAPW-1:0] cap_now;
    logic            need_evict;

    assign cap_raw    = CAPW'(1) << cap_log2_reg;
    assign cap_now    = (cap_raw > CAPW'(NUM_BLOCKS)) ? CAPW'(NUM_BLOCKS) : cap_raw;
    assign need_evict = (CAPW'(vc_reg) >= cap_now) && (vc_reg != '0);

    logic [farc_pkg::LFSR_W-1:0] lfsr_step;
    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ farc_pkg::LFSR_TAPS)
                                   : (lfsr_reg >> 1);

    // Byte lane work for the current access.
    logic [2:0]        acc_sh;
    logic [WIDX_W-1:0] acc_w0;
    logic [WIDX_W-1:0] acc_w1;
    logic              acc_cross;
    logic [DW-1:0]     acc_mask;
    logic [2*DW-1:0]   pair;
    logic [2*DW-1:0]   pair_mask;
    logic [2*DW-1:0]   merged;
    logic [DW-1:0]     rd_bytes;

    assign acc_sh    = pend_addr_reg[2:0];
    assign acc_w0    = WIDX_W'(pend_addr_reg[OFF_W-1:0] >> 3);
    assign acc_w1    = acc_w0 + WIDX_W'(1);
    assign acc_cross = (5'(acc_sh) + 5'(pend_size_reg)) > 5'd8;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            acc_mask[i*8 +: 8] = (farc_pkg::SIZE_W'(i) < pend_size_reg) ? 8'hFF : 8'h00;
        end
    end

    assign pair      = {w1_reg, w0_reg};
    assign pair_mask = {{DW{1'b0}}, acc_mask} << {acc_sh, 3'b000};
    assign merged    = (pair & ~pair_mask)
                     | ({{DW{1'b0}}, pend_data_reg & acc_mask} << {acc_sh, 3'b000});
    assign rd_bytes  = DW'(pair >> {acc_sh, 3'b000}) & acc_mask;

    // Remainder step of the victim modulo, one LFSR bit per cycle.
    logic [RW-1:0] rem_shift;
    assign rem_shift = {rem_reg[RW-2:0], modq_reg[farc_pkg::LFSR_W-1]};

    always_comb begin
        state_next      = state_reg;
        lfsr_next       = lfsr_reg;
        busy_next       = busy_reg;
        vc_next         = vc_reg;
        hits_next       = hits_reg;
        misses_next     = misses_reg;
        valid_next      = valid_reg;
        fill_cnt_next   = fill_cnt_reg;
        pend_write_next = pend_write_reg;
        pend_addr_next  = pend_addr_reg;
        pend_size_next  = pend_size_reg;
        pend_data_next  = pend_data_reg;
        pend_port_next  = pend_port_reg;
        slot_next       = slot_reg;
        acc_hit_next    = acc_hit_reg;
        wcnt_next       = wcnt_reg;
        w0_next         = w0_reg;
        w1_next         = w1_reg;
        rem_next        = rem_reg;
        modq_next       = modq_reg;
        bitc_next       = bitc_reg;
        scan_next       = scan_reg;
        seen_next       = seen_reg;
        emit            = 1'b0;
        e_kind          = farc_pkg::KIND_RESP;
        e_port          = '0;
        e_addr          = '0;
        e_data          = '0;
        e_hit           = 1'b0;
        e_last          = 1'b0;
        tag_we          = 1'b0;
        tag_wdata       = pend_addr_reg[farc_pkg::ADDR_W-1:OFF_W];
        fill_we         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = ram_index(slot_reg, wcnt_reg);
        ram_wdata       = fill_buf_reg[wcnt_reg];
        ram_raddr       = ram_index(slot_reg, acc_w0);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                if (in_func_reg == farc_pkg::FN_FILL) begin
                    if (!busy_reg) begin
                        if (out_free) begin
                            emit       = 1'b1;
                            e_kind     = farc_pkg::KIND_ERROR;
                            e_last     = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        fill_we = 1'b1;
                        if (fill_cnt_reg != WIDX_W'(WORDS - 1)) begin
                            fill_cnt_next = fill_cnt_reg + WIDX_W'(1);
                            state_next    = ST_IDLE;
                        end else begin
                            fill_cnt_next = '0;
                            wcnt_next     = '0;
                            if (need_evict) begin
                                lfsr_next  = lfsr_step;
                                modq_next  = lfsr_step;
                                rem_next   = '0;
                                bitc_next  = '0;
                                state_next = ST_MOD;
                            end else begin
                                slot_next  = free_slot;
                                vc_next    = vc_reg + VCW'(1);
                                state_next = ST_INSTALL;
                            end
                        end
                    end
                end else if (in_func_reg == farc_pkg::FN_BAD || busy_reg || bad_access) begin
                    if (out_free) begin
                        emit   = 1'b1;
                        e_kind = (in_func_reg != farc_pkg::FN_BAD && busy_reg)
                               ? farc_pkg::KIND_RETRY : farc_pkg::KIND_ERROR;
                        e_port     = in_port_reg;
                        e_addr     = in_addr_reg;
                        e_last     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    pend_write_next = (in_func_reg == farc_pkg::FN_WRITE);
                    pend_addr_next  = in_addr_reg;
                    pend_size_next  = in_size_reg;
                    pend_data_next  = in_wdata_reg;
                    pend_port_next  = in_port_reg;
                    if (hit_found) begin
                        hits_next    = hits_reg + farc_pkg::CNT_W'(1);
                        slot_next    = hit_slot;
                        acc_hit_next = 1'b1;
                        state_next   = ST_ACC_RD0;
                    end else if (out_free) begin
                        misses_next   = misses_reg + farc_pkg::CNT_W'(1);
                        busy_next     = 1'b1;
                        fill_cnt_next = '0;
                        emit          = 1'b1;
                        e_kind        = farc_pkg::KIND_RDREQ;
                        e_addr        = {in_tag, {OFF_W{1'b0}}};
                        e_last        = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        state_next = ST_DECODE;
                    end
                end
            end

            ST_MOD: begin
                rem_next  = (rem_shift >= RW'(vc_reg)) ? (rem_shift - RW'(vc_reg)) : rem_shift;
                modq_next = modq_reg << 1;
                bitc_next = bitc_reg + BITC_W'(1);
                if (bitc_reg == BITC_W'(farc_pkg::LFSR_W - 1)) begin
                    scan_next  = '0;
                    seen_next  = '0;
                    state_next = ST_SCAN;
                end
            end

            // Walk the slots to the pick-th valid one.
            ST_SCAN: begin
                if (valid_reg[scan_reg] && (seen_reg == VCW'(rem_reg))) begin
                    slot_next  = scan_reg;
                    wcnt_next  = '0;
                    state_next = ST_WB_RD;
                end else begin
                    if (valid_reg[scan_reg]) begin
                        seen_next = seen_reg + VCW'(1);
                    end
                    scan_next = scan_reg + SLOT_W'(1);
                end
            end

            ST_WB_RD: begin
                ram_raddr  = ram_index(slot_reg, wcnt_reg);
                state_next = ST_WB_EMIT;
            end

            ST_WB_EMIT: begin
                ram_raddr = ram_index(slot_reg, wcnt_reg);
                if (out_free) begin
                    emit   = 1'b1;
                    e_kind = farc_pkg::KIND_WB;
                    e_addr = {tag_reg[slot_reg], {OFF_W{1'b0}}};
                    e_data = ram_rdata;
                    if (wcnt_reg == WIDX_W'(WORDS - 1)) begin
                        wcnt_next  = '0;
                        state_next = ST_INSTALL;
                    end else begin
                        wcnt_next  = wcnt_reg + WIDX_W'(1);
                        state_next = ST_WB_RD;
                    end
                end
            end

            ST_INSTALL: begin
                ram_we = 1'b1;
                if (wcnt_reg == WIDX_W'(WORDS - 1)) begin
                    tag_we                = 1'b1;
                    valid_next[slot_reg]  = 1'b1;
                    busy_next             = 1'b0;
                    acc_hit_next          = 1'b0;
                    wcnt_next             = '0;
                    state_next            = ST_ACC_RD0;
                end else begin
                    wcnt_next = wcnt_reg + WIDX_W'(1);
                end
            end

            ST_ACC_RD0: begin
                state_next = ST_ACC_RD1;
            end

            ST_ACC_RD1: begin
                ram_raddr  = ram_index(slot_reg, acc_w1);
                w0_next    = ram_rdata;
                state_next = ST_ACC_CAP;
            end

            ST_ACC_CAP: begin
                w1_next    = ram_rdata;
                state_next = pend_write_reg ? ST_ACC_WR0 : ST_RESP;
            end

            ST_ACC_WR0: begin
                ram_we     = 1'b1;
                ram_waddr  = ram_index(slot_reg, acc_w0);
                ram_wdata  = merged[DW-1:0];
                state_next = acc_cross ? ST_ACC_WR1 : ST_RESP;
            end

            ST_ACC_WR1: begin
                ram_we     = 1'b1;
                ram_waddr  = ram_index(slot_reg, acc_w1);
                ram_wdata  = merged[2*DW-1:DW];
                state_next = ST_RESP;
            end

            ST_RESP: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = farc_pkg::KIND_RESP;
                    e_port     = pend_port_reg;
                    e_addr     = pend_addr_reg;
                    e_data     = pend_write_reg ? '0 : rd_bytes;
                    e_hit      = acc_hit_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A seed write reloads the LFSR at once; a zero seed loads one.
        if (cfg_we && cfg_index == farc_pkg::CFG_SEED) begin
            lfsr_next = (cfg_wdata == '0) ? farc_pkg::LFSR_W'(1) : cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_log2_reg <= farc_pkg::CAPLOG_RESET;
            lfsr_reg     <= farc_pkg::LFSR_RESET;
            busy_reg     <= 1'b0;
            vc_reg       <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            valid_reg    <= '0;
            fill_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            lfsr_reg     <= lfsr_next;
            busy_reg     <= busy_next;
            vc_reg       <= vc_next;
            hits_reg     <= hits_next;
            misses_reg   <= misses_next;
            valid_reg    <= valid_next;
            fill_cnt_reg <= fill_cnt_next;
            if (cfg_we && cfg_index == farc_pkg::CFG_CAPACITY) begin
                cap_log2_reg <= cfg_wdata[farc_pkg::CAPLOG_W-1:0];
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_func_reg  <= s_tuser;
            in_addr_reg  <= s_tdata[31:0];
            in_size_reg  <= s_tdata[35:32];
            in_wdata_reg <= s_tdata[99:36];
            in_fword_reg <= s_tdata[163:100];
            in_port_reg  <= s_tdata[165:164];
        end
        if (fill_we) begin
            fill_buf_reg[fill_cnt_reg] <= in_fword_reg;
        end
        if (tag_we) begin
            tag_reg[slot_reg] <= tag_wdata;
        end
        pend_write_reg <= pend_write_next;
        pend_addr_reg  <= pend_addr_next;
        pend_size_reg  <= pend_size_next;
        pend_data_reg  <= pend_data_next;
        pend_port_reg  <= pend_port_next;
        slot_reg       <= slot_next;
        acc_hit_reg    <= acc_hit_next;
        wcnt_reg       <= wcnt_next;
        w0_reg         <= w0_next;
        w1_reg         <= w1_next;
        rem_reg        <= rem_next;
        modq_reg       <= modq_next;
        bitc_reg       <= bitc_next;
        scan_reg       <= scan_next;
        seen_reg       <= seen_next;
        if (emit) begin
            m_kind_reg   <= e_kind;
            m_port_reg   <= e_port;
            m_addr_reg   <= e_addr;
            m_data_reg   <= e_data;
            m_hit_reg    <= e_hit;
            m_last_reg   <= e_last;
            m_hits_reg   <= hits_next;
            m_misses_reg <= misses_next;
        end
    end

    farc_ram #(
        .WIDTH (DW),
        .DEPTH (RAM_D)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'b00000, m_misses_reg, m_hits_reg, m_hit_reg,
                       m_data_reg, m_addr_reg, m_port_reg};

endmodule
`default_nettype wire
